// File: sv/rational_arithmetic_unit_assert.svh
// assertion macros for the rational arithmetic unit
// expects clk and arst_n in the scope of the including module
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rational_arithmetic_unit: assertion failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rational_arithmetic_unit: assertion failed");

`endif

// File: sv/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;

	localparam int NUM_WIDTH_DEF = 32;
	localparam int NUM_W         = 32;
	localparam int DEN_W         = 31;
	localparam int WIDE_W        = 64;

	localparam logic [2:0] K_ADD  = 3'd0;
	localparam logic [2:0] K_SUB  = 3'd1;
	localparam logic [2:0] K_MUL  = 3'd2;
	localparam logic [2:0] K_DIV  = 3'd3;
	localparam logic [2:0] K_NEG  = 3'd4;
	localparam logic [2:0] K_INV  = 3'd5;
	localparam logic [2:0] K_ABS  = 3'd6;
	localparam logic [2:0] K_NONE = 3'd7;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DIVZERO  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0]              kind;
		logic signed [NUM_W-1:0] a_num;
		logic [DEN_W-1:0]        a_den;
		logic signed [NUM_W-1:0] b_num;
		logic [DEN_W-1:0]        b_den;
	} item_in_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] res_num;
		logic [DEN_W-1:0]        res_den;
		logic [1:0]              status;
	} item_out_t;

	// status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

// File: sv/rau_mul.sv
// registered 32 x 32 unsigned multiplier shared by all product steps
// depends on rau_pkg
module rau_mul (
	input  logic                             clk,
	input  logic [rau_pkg::NUM_W-1:0]        op_a,
	input  logic [rau_pkg::NUM_W-1:0]        op_b,
	output logic [2*rau_pkg::NUM_W-1:0]      prod_q
);

	logic [2*rau_pkg::NUM_W-1:0] prod;

	assign prod = op_a * op_b;

	always_ff @(posedge clk) begin
		prod_q <= prod;
	end

endmodule

// File: sv/rau_gcd.sv
// binary gcd unit, one shift or subtract step per cycle
// depends on rau_pkg; y_in must be nonzero
module rau_gcd #(
	parameter int WIDTH = rau_pkg::WIDE_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [WIDTH-1:0]   x_in,
	input  logic [WIDTH-1:0]   y_in,
	output logic [WIDTH-1:0]   g,
	output rau_pkg::unit_sts_t sts
);

	localparam int K_W = $clog2(WIDTH);

	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] g_q;
	logic [K_W-1:0]   k_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   dxy;
	logic [WIDTH-1:0] dyx;
	logic             x_ge;

	assign dxy  = {1'b0, x_q} - {1'b0, y_q};
	assign dyx  = y_q - x_q;
	assign x_ge = ~dxy[WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && x_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_in;
			y_q <= y_in;
			k_q <= '0;
		end else if (busy_q) begin
			if (x_q == '0) begin
				g_q <= y_q << k_q;
			end else if (!x_q[0] && !y_q[0]) begin
				// common factor of two
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_ge) begin
				// both odd, difference is even
				x_q <= dxy[WIDTH:1];
			end else begin
				y_q <= {1'b0, dyx[WIDTH-1:1]};
			end
		end
	end

	assign g   = g_q;
	assign sts = '{busy: busy_q, done: done_q};

endmodule

// File: sv/rau_div.sv
// restoring divider, one quotient bit per cycle
// depends on rau_pkg
module rau_div #(
	parameter int WIDTH = rau_pkg::WIDE_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [WIDTH-1:0]   dividend,
	input  logic [WIDTH-1:0]   divisor,
	output logic [WIDTH-1:0]   quo,
	output rau_pkg::unit_sts_t sts
);

	localparam int CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   rem_sh;
	logic [WIDTH:0]   trial;
	logic             fit;

	assign rem_sh = {rem_q, quo_q[WIDTH-1]};
	assign trial  = rem_sh - {1'b0, dvsr_q};
	assign fit    = ~trial[WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? trial[WIDTH-1:0] : rem_sh[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fit};
		end
	end

	assign quo = quo_q;
	assign sts = '{busy: busy_q, done: done_q};

endmodule

// File: sv/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit: sequencer, operand registers, result register
// depends on rau_pkg, rau_mul, rau_gcd, rau_div and rational_arithmetic_unit_assert.svh
//
// One command is taken when start is high and busy is low; busy stays high until the
// result is shown. The result sits on res for exactly one cycle with done high and must
// be taken then, there is no way to hold it. Negate, invert and absolute value go from
// the check state straight to the fit state; an undefined kind, a zero denominator or a
// zero divisor finishes in the check state. Add, subtract, multiply and divide run their
// products through one shared 32x32 multiplier (each product is issued, then taken from
// its output register), reduce by a binary gcd loop on 64-bit values, then divide numerator
// and denominator by the gcd in turn in a bit-serial divider; the gcd loop and the two
// divisions set most of a command's run time.
`include "rational_arithmetic_unit_assert.svh"

module rational_arithmetic_unit #(
	parameter int NUM_WIDTH = rau_pkg::NUM_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rau_pkg::item_in_t  cmd,
	output logic               done,
	output rau_pkg::item_out_t res
);

	localparam int NW = rau_pkg::NUM_W;
	localparam int DW = rau_pkg::DEN_W;
	localparam int WW = rau_pkg::WIDE_W;

	localparam logic [WW-1:0] LIM    = WW'(1) << (NUM_WIDTH - 1);
	localparam logic [WW-1:0] LIM_M1 = LIM - WW'(1);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_CHECK     = 4'd1;
	localparam logic [3:0] S_MUL_ISSUE = 4'd2;
	localparam logic [3:0] S_MUL_TAKE  = 4'd3;
	localparam logic [3:0] S_COMB      = 4'd4;
	localparam logic [3:0] S_GCD       = 4'd5;
	localparam logic [3:0] S_DIV_MAG   = 4'd6;
	localparam logic [3:0] S_DIV_DEN   = 4'd7;
	localparam logic [3:0] S_FIT       = 4'd8;

	localparam logic [1:0] STEP_LAST_SUM  = 2'd2;
	localparam logic [1:0] STEP_LAST_PROD = 2'd1;

	function automatic logic [NW-1:0] mag_of(input logic [NW-1:0] v);
		mag_of = v[NW-1] ? (NW'(0) - v) : v;
	endfunction

	logic [3:0]     state_q;
	logic [1:0]     step_q;
	logic           done_q;

	logic [2:0]     kind_q;
	logic           a_neg_q;
	logic [NW-1:0]  a_mag_q;
	logic [DW-1:0]  a_den_q;
	logic           b_neg_q;
	logic [NW-1:0]  b_mag_q;
	logic [DW-1:0]  b_den_q;
	logic [WW-1:0]  t1_q;
	logic [WW-1:0]  t2_q;
	logic [WW-1:0]  mag_q;
	logic [WW-1:0]  den_q;
	logic           neg_q;
	rau_pkg::item_out_t res_q;

	logic           accept;
	logic           is_sum;
	logic           is_unary;
	logic           chk_none;
	logic           chk_dz;
	logic [1:0]     last_step;
	logic [NW-1:0]  op_a;
	logic [NW-1:0]  op_b;
	logic [WW-1:0]  prod_q;

	logic           b_neg_eff;
	logic [WW-1:0]  sum12;
	logic [WW:0]    d12;
	logic [WW-1:0]  d21;
	logic [WW-1:0]  comb_mag;
	logic [WW-1:0]  comb_den;
	logic           comb_neg;

	logic           gcd_start;
	logic [WW-1:0]  gcd_g;
	rau_pkg::unit_sts_t gcd_sts;
	logic           div_start;
	logic [WW-1:0]  div_dividend;
	logic [WW-1:0]  div_quo;
	rau_pkg::unit_sts_t div_sts;

	logic           fit_ok;
	logic [NW-1:0]  fit_num;

	assign accept   = start && (state_q == S_IDLE);
	assign is_sum   = (kind_q == rau_pkg::K_ADD) || (kind_q == rau_pkg::K_SUB);
	assign is_unary = (kind_q == rau_pkg::K_NEG) || (kind_q == rau_pkg::K_INV)
		|| (kind_q == rau_pkg::K_ABS);
	assign chk_none = (kind_q == rau_pkg::K_NONE);
	assign chk_dz   = (a_den_q == '0)
		|| (kind_q <= rau_pkg::K_DIV && b_den_q == '0)
		|| (kind_q == rau_pkg::K_DIV && b_mag_q == '0)
		|| (kind_q == rau_pkg::K_INV && a_mag_q == '0);
	assign last_step = is_sum ? STEP_LAST_SUM : STEP_LAST_PROD;

	// operand select for the shared multiplier
	always_comb begin
		op_a = {1'b0, a_den_q};
		op_b = {1'b0, b_den_q};
		case (step_q)
			2'd0: begin
				op_a = a_mag_q;
				op_b = (kind_q == rau_pkg::K_MUL) ? b_mag_q : {1'b0, b_den_q};
			end
			2'd1: begin
				case (kind_q) inside
					rau_pkg::K_ADD, rau_pkg::K_SUB: begin
						op_a = b_mag_q;
						op_b = {1'b0, a_den_q};
					end
					rau_pkg::K_DIV: begin
						op_a = {1'b0, a_den_q};
						op_b = b_mag_q;
					end
					default: begin
						op_a = {1'b0, a_den_q};
						op_b = {1'b0, b_den_q};
					end
				endcase
			end
			default: begin
				op_a = {1'b0, a_den_q};
				op_b = {1'b0, b_den_q};
			end
		endcase
	end

	rau_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// signed combine of the two cross products for add and subtract; other kinds pass t1 and t2 through
	assign b_neg_eff = (kind_q == rau_pkg::K_SUB) ? ~b_neg_q : b_neg_q;
	assign sum12     = t1_q + t2_q;
	assign d12       = {1'b0, t1_q} - {1'b0, t2_q};
	assign d21       = t2_q - t1_q;

	always_comb begin
		comb_mag = t1_q;
		comb_den = t2_q;
		comb_neg = a_neg_q ^ b_neg_q;
		if (is_sum) begin
			comb_den = den_q;
			if (a_neg_q == b_neg_eff) begin
				comb_mag = sum12;
				comb_neg = a_neg_q;
			end else if (!d12[WW]) begin
				comb_mag = d12[WW-1:0];
				comb_neg = a_neg_q;
			end else begin
				comb_mag = d21;
				comb_neg = b_neg_eff;
			end
		end
	end

	assign gcd_start = (state_q == S_COMB);

	rau_gcd #(.WIDTH(WW)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.x_in   (comb_mag),
		.y_in   (comb_den),
		.g      (gcd_g),
		.sts    (gcd_sts)
	);

	assign div_start = (state_q == S_GCD && gcd_sts.done)
		|| (state_q == S_DIV_MAG && div_sts.done);
	assign div_dividend = (state_q == S_GCD) ? mag_q : den_q;

	rau_div #(.WIDTH(WW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (gcd_g),
		.quo      (div_quo),
		.sts      (div_sts)
	);

	assign fit_ok = (den_q != '0) && (den_q <= LIM_M1)
		&& (neg_q ? (mag_q <= LIM) : (mag_q <= LIM_M1));
	assign fit_num = neg_q ? (NW'(0) - mag_q[NW-1:0]) : mag_q[NW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					step_q <= '0;
					if (chk_none || chk_dz) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else if (is_unary) begin
						state_q <= S_FIT;
					end else begin
						state_q <= S_MUL_ISSUE;
					end
				end
				S_MUL_ISSUE: state_q <= S_MUL_TAKE;
				S_MUL_TAKE: begin
					if (step_q == last_step) begin
						state_q <= S_COMB;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_MUL_ISSUE;
					end
				end
				S_COMB: state_q <= S_GCD;
				S_GCD: begin
					if (gcd_sts.done) begin
						state_q <= S_DIV_MAG;
					end
				end
				S_DIV_MAG: begin
					if (div_sts.done) begin
						state_q <= S_DIV_DEN;
					end
				end
				S_DIV_DEN: begin
					if (div_sts.done) begin
						state_q <= S_FIT;
					end
				end
				S_FIT: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= cmd.kind;
			a_neg_q <= cmd.a_num[NW-1];
			a_mag_q <= mag_of(cmd.a_num);
			a_den_q <= cmd.a_den;
			b_neg_q <= cmd.b_num[NW-1];
			b_mag_q <= mag_of(cmd.b_num);
			b_den_q <= cmd.b_den;
		end
		case (state_q)
			S_CHECK: begin
				res_q <= '{res_num: '0, res_den: DW'(1),
					status: (!chk_none && chk_dz) ? rau_pkg::ST_DIVZERO : rau_pkg::ST_OK};
				case (kind_q)
					rau_pkg::K_INV: begin
						mag_q <= {{(WW-DW){1'b0}}, a_den_q};
						den_q <= {{(WW-NW){1'b0}}, a_mag_q};
						neg_q <= a_neg_q;
					end
					rau_pkg::K_NEG: begin
						mag_q <= {{(WW-NW){1'b0}}, a_mag_q};
						den_q <= {{(WW-DW){1'b0}}, a_den_q};
						neg_q <= (a_mag_q != '0) && !a_neg_q;
					end
					default: begin
						mag_q <= {{(WW-NW){1'b0}}, a_mag_q};
						den_q <= {{(WW-DW){1'b0}}, a_den_q};
						neg_q <= 1'b0;
					end
				endcase
			end
			S_MUL_TAKE: begin
				case (step_q)
					2'd0:    t1_q  <= prod_q;
					2'd1:    t2_q  <= prod_q;
					default: den_q <= prod_q;
				endcase
			end
			S_COMB: begin
				mag_q <= comb_mag;
				den_q <= comb_den;
				neg_q <= comb_neg;
			end
			S_DIV_MAG: begin
				if (div_sts.done) begin
					mag_q <= div_quo;
					// zero result carries no sign
					neg_q <= neg_q && (div_quo != '0);
				end
			end
			S_DIV_DEN: begin
				if (div_sts.done) begin
					den_q <= div_quo;
				end
			end
			S_FIT: begin
				if (fit_ok) begin
					res_q <= '{res_num: fit_num, res_den: den_q[DW-1:0],
						status: rau_pkg::ST_OK};
				end else begin
					res_q <= '{res_num: '0, res_den: DW'(1), status: rau_pkg::ST_OVERFLOW};
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	`RAU_ASSERT_NEXT(a_transfer_busy, start && !busy, busy)
	`RAU_ASSERT_IMPL(a_den_positive, done, res.res_den != '0)
	`RAU_ASSERT_IMPL(a_err_zero, done && |res.status, res.res_num == '0 && res.res_den == DW'(1))
	`RAU_ASSERT_IMPL(a_gcd_start_idle, gcd_start, !gcd_sts.busy)
	`RAU_ASSERT_IMPL(a_div_start_idle, div_start, !div_sts.busy)

endmodule
